>>> src/ccq_pkg.sv
// Package for the coalescing command queue: payload structs, status codes, constants.
// No dependencies.
`default_nettype none
package ccq_pkg;
    localparam int QueueDepthDefault = 16;
    localparam logic [13:0] LimitAReset = 14'd9830;
    localparam logic [13:0] LimitBReset = 14'd7373;
    localparam logic [2:0] KIND_ACCUM = 3'd1;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_COALESCED = 3'd1,
        ST_EVICTED = 3'd2,
        ST_REJECTED = 3'd3,
        ST_POPPED = 3'd4,
        ST_EMPTY = 3'd5
    } t_status;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP = 1'b1;
    localparam logic CFG_LIMIT_A = 1'b0;
    localparam logic CFG_LIMIT_B = 1'b1;

    typedef struct packed {
        logic req_type;
        logic [2:0] cmd_kind;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic flag_in;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] out_kind;
        logic signed [15:0] out_a;
        logic signed [15:0] out_b;
        logic out_flag;
        logic [31:0] out_sequence;
        logic [4:0] occupancy;
    } t_out;

    // One queue entry as stored in memory.
    typedef struct packed {
        logic [2:0] kind;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic flag;
        logic [31:0] sequence_num;
    } t_entry;

    // Symmetric clamp of a 17-bit sum to +-limit.
    function automatic logic signed [15:0] clamp_sym(logic signed [16:0] v, logic [13:0] lim);
        logic signed [16:0] l;
        begin
            l = signed'({3'b000, lim});
            if (v > l) clamp_sym = l[15:0];
            else if (v < -l) clamp_sym = 16'(-l);
            else clamp_sym = v[15:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> src/coalescing_command_queue_top.sv
// Top level of the coalescing command queue: sequencer over one entry memory.
// Depends on ccq_pkg.
//
// Usage: requests arrive on i_in (valid/stall); each yields exactly one result on
// o_out (valid/stall). A push of a coalescible kind walks the queue from newest to
// oldest, one memory read per entry, stopping at a critical entry or a match.
// A full-queue append walks from the head to find the oldest coalescible entry and
// then moves later entries up one slot, one read and one write per entry.
// A push takes longer as occupancy grows, longest for an eviction: the walk over
// the entry memory sets its duration. One request is in flight at a time.
// A finished result sits in the output register; the next request is taken while it
// waits, and processing of that request stops only if it finishes while the
// previous result is still stalled.
// Reset clears pointers, count and sequence number (to one) and reloads the limit
// registers; the entry memory is not cleared and needs no clearing pass.
`default_nettype none
module coalescing_command_queue_top
    import ccq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_stall,
    input  wire t_in i_in,
    output logic o_valid,
    input  wire logic i_stall,
    output t_out o_out,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_FULL, S_EV_RD, S_EV_CHK,
        S_SH_RD, S_SH_WR, S_APPEND, S_POP_RD, S_POP_OUT, S_DONE
    } t_state;

    t_state r_state;
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [31:0] r_seq;
    logic [13:0] r_lim_a, r_lim_b;
    t_in r_req;
    logic [CW-1:0] r_off;
    t_out r_res;
    logic r_out_valid;
    t_out r_out;
    logic [2:0] r_status;

    // Memory port: one read and one write per cycle.
    logic mem_re, mem_we;
    logic [IW-1:0] mem_raddr, mem_waddr;
    t_entry mem_wdata;

    function automatic logic [IW-1:0] slot(logic [IW-1:0] h, logic [CW-1:0] off);
        logic [CW:0] s;
        begin
            s = {1'b0, off} + (CW+1)'(h);
            if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
            slot = s[IW-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    logic coal_req, can_take, out_free;
    assign coal_req = (r_req.cmd_kind <= 3'd3);
    assign out_free = !r_out_valid || !i_stall;
    assign can_take = (r_state == S_IDLE);
    assign o_stall = !can_take;
    assign o_valid = r_out_valid;
    assign o_out = r_out;

    // Combinational memory control derived from state.
    always_comb begin
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = r_rdata;
        case (r_state)
            S_SRCH_RD: begin
                mem_re = 1'b1;
                mem_raddr = slot(r_head, r_count - r_off - CW'(1));
            end
            S_SRCH_CHK: begin
                if (r_rdata.kind <= 3'd3 && r_rdata.kind == r_req.cmd_kind) begin
                    mem_we = 1'b1;
                    mem_waddr = slot(r_head, r_count - r_off - CW'(1));
                    if (r_req.cmd_kind == KIND_ACCUM) begin
                        mem_wdata.a = clamp_sym(17'(r_rdata.a) + 17'(r_req.value_a), r_lim_a);
                        mem_wdata.b = clamp_sym(17'(r_rdata.b) + 17'(r_req.value_b), r_lim_b);
                    end else begin
                        mem_wdata.a = r_req.value_a;
                        mem_wdata.b = r_req.value_b;
                        mem_wdata.flag = r_req.flag_in;
                    end
                end
            end
            S_EV_RD, S_POP_RD: begin
                mem_re = 1'b1;
                mem_raddr = slot(r_head, r_off);
            end
            S_SH_RD: begin
                mem_re = 1'b1;
                mem_raddr = slot(r_head, r_off + CW'(1));
            end
            S_SH_WR: begin
                mem_we = 1'b1;
                mem_waddr = slot(r_head, r_off);
            end
            S_APPEND: begin
                mem_we = 1'b1;
                mem_waddr = slot(r_head, r_count);
                mem_wdata.kind = r_req.cmd_kind;
                mem_wdata.a = coal_req ? r_req.value_a : '0;
                mem_wdata.b = coal_req ? r_req.value_b : '0;
                mem_wdata.flag = coal_req ? r_req.flag_in : 1'b0;
                mem_wdata.sequence_num = r_seq;
            end
            default: ;
        endcase
    end

    // Sequencer, registers and output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_count <= '0;
            r_seq <= 32'd1;
            r_lim_a <= LimitAReset;
            r_lim_b <= LimitBReset;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LIMIT_A) r_lim_a <= i_cfg_data;
                else r_lim_b <= i_cfg_data;
            end
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_in;
                        r_off <= '0;
                        r_res <= '0;
                        if (i_in.req_type == REQ_POP) begin
                            if (r_count == '0) begin
                                r_res.status <= ST_EMPTY;
                                r_res.occupancy <= 5'(r_count);
                                r_state <= S_DONE;
                            end else r_state <= S_POP_RD;
                        end else if (i_in.cmd_kind <= 3'd3 && r_count != '0)
                            r_state <= S_SRCH_RD;
                        else r_state <= S_FULL;
                    end
                end
                S_SRCH_RD: r_state <= S_SRCH_CHK;
                S_SRCH_CHK: begin
                    if (r_rdata.kind > 3'd3) r_state <= S_FULL;
                    else if (r_rdata.kind == r_req.cmd_kind) begin
                        r_res.status <= ST_COALESCED;
                        r_res.occupancy <= 5'(r_count);
                        r_state <= S_DONE;
                    end else if (r_off + CW'(1) == r_count) r_state <= S_FULL;
                    else begin
                        r_off <= r_off + CW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_FULL: begin
                    r_off <= '0;
                    r_status <= ST_APPENDED;
                    if (r_count == CW'(QUEUE_DEPTH)) r_state <= S_EV_RD;
                    else r_state <= S_APPEND;
                end
                S_EV_RD: r_state <= S_EV_CHK;
                S_EV_CHK: begin
                    if (r_rdata.kind <= 3'd3) begin
                        r_status <= ST_EVICTED;
                        if (r_off + CW'(1) == r_count) begin
                            r_count <= r_count - CW'(1);
                            r_state <= S_APPEND;
                        end else r_state <= S_SH_RD;
                    end else if (r_off + CW'(1) == r_count) begin
                        r_res.status <= ST_REJECTED;
                        r_res.occupancy <= 5'(r_count);
                        r_state <= S_DONE;
                    end else begin
                        r_off <= r_off + CW'(1);
                        r_state <= S_EV_RD;
                    end
                end
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    if (r_off + CW'(2) == r_count) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_APPEND;
                    end else begin
                        r_off <= r_off + CW'(1);
                        r_state <= S_SH_RD;
                    end
                end
                S_APPEND: begin
                    r_seq <= r_seq + 32'd1;
                    r_count <= r_count + CW'(1);
                    r_res.status <= r_status;
                    r_res.occupancy <= 5'(r_count + CW'(1));
                    r_state <= S_DONE;
                end
                S_POP_RD: r_state <= S_POP_OUT;
                S_POP_OUT: begin
                    r_res.status <= ST_POPPED;
                    r_res.out_kind <= r_rdata.kind;
                    r_res.out_a <= r_rdata.a;
                    r_res.out_b <= r_rdata.b;
                    r_res.out_flag <= r_rdata.flag;
                    r_res.out_sequence <= r_rdata.sequence_num;
                    r_res.occupancy <= 5'(r_count - CW'(1));
                    r_count <= r_count - CW'(1);
                    r_head <= slot(r_head, CW'(1));
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= r_res;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/ccq_checker.sv
// Port-level checker for the coalescing command queue, bound to the top level.
// Depends on ccq_pkg.
`default_nettype none
module ccq_checker
    import ccq_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_out o_out
);
    // A stalled result transfer holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out)) else $error("result changed under stall");
    // Status codes stay in range.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.status <= ST_EMPTY) else $error("bad status");
    // Occupancy never exceeds 16, the default queue depth.
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.occupancy <= 5'd16) else $error("occupancy overflow");
    // Non-pop results carry zero sequence number and kind.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.status != ST_POPPED |-> o_out.out_sequence == 32'd0 &&
        o_out.out_kind == 3'd0) else $error("payload on non-pop");
    // An accepted request keeps the queue busy in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("request not held busy");
endmodule

bind coalescing_command_queue_top ccq_checker u_ccq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out)
);
`default_nettype wire
